// File: rtl/gfnb_pkg.sv
// gfnb_pkg: constants, types and the multiplier matrix for the GF(2^173)
// normal basis unit. No dependencies.
package gfnb_pkg;

    localparam int FIELD_BITS = 173;
    localparam int WORD_COUNT = 3;
    localparam int WORD_BITS  = 64;
    localparam int TOP_BITS   = FIELD_BITS - WORD_BITS * (WORD_COUNT - 1);
    localparam int ONB_P      = 2 * FIELD_BITS + 1;

    typedef logic [FIELD_BITS-1:0] t_elem;
    typedef logic [FIELD_BITS-1:0][FIELD_BITS-1:0] t_mat;

    localparam logic [7:0] FB_LAST = 8'(FIELD_BITS - 1);
    localparam logic [7:0] FB_CNT  = 8'(FIELD_BITS);
    localparam logic [7:0] INV_EXP = 8'(FIELD_BITS - 1);
    localparam logic [2:0] INV_TOPM1 = 3'd6;

    // commands
    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_MUL   = 3'd1;
    localparam logic [2:0] OP_SQR   = 3'd2;
    localparam logic [2:0] OP_POW   = 3'd3;
    localparam logic [2:0] OP_INV   = 3'd4;
    localparam logic [2:0] OP_TRACE = 3'd5;

    localparam logic [1:0] WIDX_START = 2'd2;
    localparam logic [1:0] WIDX_NONE  = 2'd3;

    // datapath x register select
    localparam logic [2:0] X_HOLD  = 3'd0;
    localparam logic [2:0] X_A     = 3'd1;
    localparam logic [2:0] X_XOR   = 3'd2;
    localparam logic [2:0] X_ROTD  = 3'd3;
    localparam logic [2:0] X_R     = 3'd4;
    localparam logic [2:0] X_ONES  = 3'd5;
    localparam logic [2:0] X_TRACE = 3'd6;

    localparam logic [1:0] Y_HOLD = 2'd0;
    localparam logic [1:0] Y_A    = 2'd1;
    localparam logic [1:0] Y_B    = 2'd2;
    localparam logic [1:0] Y_P    = 2'd3;

    localparam logic [1:0] P_HOLD = 2'd0;
    localparam logic [1:0] P_A    = 2'd1;
    localparam logic [1:0] P_X    = 2'd2;

    typedef struct packed {
        logic [2:0] x_sel;
        logic [1:0] y_sel;
        logic [1:0] p_sel;
        logic       e_load;
        logic       e_shift;
        logic       mul_step;
    } t_dp_cmd;

    typedef struct packed {
        logic e_top;
    } t_dp_status;

    // column masks: col[j] bit (172-i) set when 2^i +- 2^j == +-1 mod p
    function automatic t_mat build_col();
        t_mat m;
        int   pw [FIELD_BITS];
        int   v;
        int   s;
        int   d;
        m = '0;
        v = 1;
        for (int i = 0; i < FIELD_BITS; i++) begin
            pw[i] = v;
            v = (v * 2) % ONB_P;
        end
        for (int j = 0; j < FIELD_BITS; j++) begin
            for (int i = 0; i < FIELD_BITS; i++) begin
                s = (pw[i] + pw[j]) % ONB_P;
                d = pw[i] - pw[j];
                if (s == 1 || s == ONB_P - 1 || d == 1 || d == -1 ||
                    d == ONB_P - 1 || d == 1 - ONB_P) begin
                    m[j][FIELD_BITS-1-i] = 1'b1;
                end
            end
        end
        return m;
    endfunction

    localparam t_mat COL_MASK = build_col();

    // one Massey-Omura product bit
    function automatic logic mo_bit(t_elem x, t_elem y);
        logic b;
        b = 1'b0;
        for (int j = 0; j < FIELD_BITS; j++) begin
            b = b ^ (y[FIELD_BITS-1-j] & (^(COL_MASK[j] & x)));
        end
        return b;
    endfunction

endpackage

// File: rtl/gfnb_if.sv
// gfnb_in_if / gfnb_out_if: valid-ready channels of the normal basis unit.
// Depends on nothing.
interface gfnb_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [1:0]  word_index;
    logic [63:0] operand_a_word;
    logic [63:0] operand_b_word;
    modport source (output valid, command, word_index, operand_a_word, operand_b_word,
                    input ready);
    modport sink (input valid, command, word_index, operand_a_word, operand_b_word,
                  output ready);
endinterface

interface gfnb_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_word;
    logic [1:0]  result_index;
    logic        last;
    modport source (output valid, result_word, result_index, last, input ready);
    modport sink (input valid, result_word, result_index, last, output ready);
endinterface

// File: rtl/gfnb_dpath.sv
// gfnb_dpath: operand stores, working registers and bit-serial multiplier.
// Depends on gfnb_pkg.
module gfnb_dpath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [1:0]           i_wr_idx,
    input  logic [63:0]          i_a_word,
    input  logic [63:0]          i_b_word,
    input  gfnb_pkg::t_dp_cmd    i_cmd,
    input  logic [1:0]           i_out_idx,
    output gfnb_pkg::t_dp_status o_status,
    output logic [63:0]          o_word
);
    gfnb_pkg::t_elem r_a, r_b, r_x, r_y, r_p, r_e, r_r;
    gfnb_pkg::t_elem n_x, n_y, n_p, n_e;
    logic            mbit;
    logic [gfnb_pkg::WORD_BITS*gfnb_pkg::WORD_COUNT-1:0] ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0;
            r_b <= '0;
        end else if (i_wr_en) begin
            unique case (i_wr_idx)
                2'd0: begin
                    r_a[63:0] <= i_a_word;
                    r_b[63:0] <= i_b_word;
                end
                2'd1: begin
                    r_a[127:64] <= i_a_word;
                    r_b[127:64] <= i_b_word;
                end
                gfnb_pkg::WIDX_START: begin
                    r_a[gfnb_pkg::FIELD_BITS-1:128] <= i_a_word[gfnb_pkg::TOP_BITS-1:0];
                    r_b[gfnb_pkg::FIELD_BITS-1:128] <= i_b_word[gfnb_pkg::TOP_BITS-1:0];
                end
                default: ;
            endcase
        end
    end

    assign mbit = gfnb_pkg::mo_bit(r_x, r_y);

    always_comb begin
        n_x = r_x;
        unique case (i_cmd.x_sel)
            gfnb_pkg::X_A:     n_x = r_a;
            gfnb_pkg::X_XOR:   n_x = r_a ^ r_b;
            gfnb_pkg::X_ROTD:  n_x = {r_x[0], r_x[gfnb_pkg::FIELD_BITS-1:1]};
            gfnb_pkg::X_R:     n_x = r_r;
            gfnb_pkg::X_ONES:  n_x = '1;
            gfnb_pkg::X_TRACE: n_x = {{(gfnb_pkg::FIELD_BITS-1){1'b0}}, ^r_a};
            default:           n_x = r_x;
        endcase
        n_y = r_y;
        unique case (i_cmd.y_sel)
            gfnb_pkg::Y_A: n_y = r_a;
            gfnb_pkg::Y_B: n_y = r_b;
            gfnb_pkg::Y_P: n_y = r_p;
            default:       n_y = r_y;
        endcase
        n_p = r_p;
        unique case (i_cmd.p_sel)
            gfnb_pkg::P_A: n_p = r_a;
            gfnb_pkg::P_X: n_p = r_x;
            default:       n_p = r_p;
        endcase
        n_e = r_e;
        if (i_cmd.e_load) begin
            n_e = r_b;
        end else if (i_cmd.e_shift) begin
            n_e = {r_e[gfnb_pkg::FIELD_BITS-2:0], 1'b0};
        end
        if (i_cmd.mul_step) begin
            n_x = {r_x[gfnb_pkg::FIELD_BITS-2:0], r_x[gfnb_pkg::FIELD_BITS-1]};
            n_y = {r_y[gfnb_pkg::FIELD_BITS-2:0], r_y[gfnb_pkg::FIELD_BITS-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_p <= n_p;
        r_e <= n_e;
        if (i_cmd.mul_step) begin
            r_r <= {r_r[gfnb_pkg::FIELD_BITS-2:0], mbit};
        end
    end

    assign o_status.e_top = r_e[gfnb_pkg::FIELD_BITS-1];

    assign ext = {{(gfnb_pkg::WORD_BITS*gfnb_pkg::WORD_COUNT-gfnb_pkg::FIELD_BITS){1'b0}}, r_x};

    always_comb begin
        unique case (i_out_idx)
            2'd0:    o_word = ext[63:0];
            2'd1:    o_word = ext[127:64];
            default: o_word = ext[191:128];
        endcase
    end

endmodule

// File: rtl/gfnb_ctrl.sv
// gfnb_ctrl: sequencer for add, multiply, square, power, inverse and trace.
// Depends on gfnb_pkg; drives gfnb_dpath through t_dp_cmd.
module gfnb_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [2:0]           i_command,
    input  logic [1:0]           i_word_index,
    output logic                 o_in_ready,
    input  gfnb_pkg::t_dp_status i_status,
    output gfnb_pkg::t_dp_cmd    o_cmd,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_out_idx,
    output logic                 o_out_last
);
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DISP    = 4'd1;
    localparam logic [3:0] S_MUL     = 4'd2;
    localparam logic [3:0] S_MUL_END = 4'd3;
    localparam logic [3:0] S_PW_BIT  = 4'd4;
    localparam logic [3:0] S_INV_ROT = 4'd5;
    localparam logic [3:0] S_INV_R1  = 4'd6;
    localparam logic [3:0] S_INV_NXT = 4'd7;
    localparam logic [3:0] S_FIN_ROT = 4'd8;
    localparam logic [3:0] S_OUT     = 4'd9;

    logic [3:0] r_state, n_state;
    logic [2:0] r_op, n_op;
    logic [7:0] r_cnt, n_cnt;
    logic [7:0] r_mcnt, n_mcnt;
    logic [7:0] r_k, n_k;
    logic [2:0] r_i, n_i;
    logic       r_started, n_started;
    logic       r_phase, n_phase;
    logic [1:0] r_widx, n_widx;
    logic       in_xfer, out_xfer;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_op      <= gfnb_pkg::OP_ADD;
            r_cnt     <= '0;
            r_mcnt    <= '0;
            r_k       <= '0;
            r_i       <= '0;
            r_started <= 1'b0;
            r_phase   <= 1'b0;
            r_widx    <= '0;
        end else begin
            r_state   <= n_state;
            r_op      <= n_op;
            r_cnt     <= n_cnt;
            r_mcnt    <= n_mcnt;
            r_k       <= n_k;
            r_i       <= n_i;
            r_started <= n_started;
            r_phase   <= n_phase;
            r_widx    <= n_widx;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_cnt     = r_cnt;
        n_mcnt    = r_mcnt;
        n_k       = r_k;
        n_i       = r_i;
        n_started = r_started;
        n_phase   = r_phase;
        n_widx    = r_widx;
        o_cmd     = '{x_sel: gfnb_pkg::X_HOLD, y_sel: gfnb_pkg::Y_HOLD,
                      p_sel: gfnb_pkg::P_HOLD, e_load: 1'b0, e_shift: 1'b0,
                      mul_step: 1'b0};
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_out_last  = (r_op == gfnb_pkg::OP_TRACE) || (r_widx == gfnb_pkg::WIDX_START);
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (in_xfer && i_word_index == gfnb_pkg::WIDX_START &&
                    i_command <= gfnb_pkg::OP_TRACE) begin
                    n_op    = i_command;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_cnt  = '0;
                n_mcnt = '0;
                unique case (r_op)
                    gfnb_pkg::OP_ADD: begin
                        o_cmd.x_sel = gfnb_pkg::X_XOR;
                        n_state = S_OUT;
                    end
                    gfnb_pkg::OP_MUL: begin
                        o_cmd.x_sel = gfnb_pkg::X_A;
                        o_cmd.y_sel = gfnb_pkg::Y_B;
                        n_state = S_MUL;
                    end
                    gfnb_pkg::OP_SQR: begin
                        o_cmd.x_sel = gfnb_pkg::X_A;
                        n_state = S_FIN_ROT;
                    end
                    gfnb_pkg::OP_POW: begin
                        o_cmd.e_load = 1'b1;
                        n_started = 1'b0;
                        n_state = S_PW_BIT;
                    end
                    gfnb_pkg::OP_INV: begin
                        o_cmd.x_sel = gfnb_pkg::X_A;
                        o_cmd.p_sel = gfnb_pkg::P_A;
                        n_i = gfnb_pkg::INV_TOPM1;
                        n_k = 8'd1;
                        n_state = S_INV_ROT;
                    end
                    default: begin
                        o_cmd.x_sel = gfnb_pkg::X_TRACE;
                        n_state = S_OUT;
                    end
                endcase
            end
            S_PW_BIT: begin
                o_cmd.e_shift = 1'b1;
                n_cnt = r_cnt + 8'd1;
                if (!r_started) begin
                    if (i_status.e_top) begin
                        o_cmd.x_sel = gfnb_pkg::X_A;
                        n_started = 1'b1;
                    end else if (r_cnt == gfnb_pkg::FB_LAST) begin
                        o_cmd.x_sel = gfnb_pkg::X_ONES;
                    end
                    if (r_cnt == gfnb_pkg::FB_LAST) begin
                        n_state = S_OUT;
                    end
                end else begin
                    o_cmd.x_sel = gfnb_pkg::X_ROTD;
                    if (i_status.e_top) begin
                        o_cmd.y_sel = gfnb_pkg::Y_A;
                        n_mcnt = '0;
                        n_state = S_MUL;
                    end else if (r_cnt == gfnb_pkg::FB_LAST) begin
                        n_state = S_OUT;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_mcnt = r_mcnt + 8'd1;
                if (r_mcnt == gfnb_pkg::FB_LAST) begin
                    n_state = S_MUL_END;
                end
            end
            S_MUL_END: begin
                o_cmd.x_sel = gfnb_pkg::X_R;
                unique case (r_op)
                    gfnb_pkg::OP_POW: begin
                        n_state = (r_cnt == gfnb_pkg::FB_CNT) ? S_OUT : S_PW_BIT;
                    end
                    gfnb_pkg::OP_INV: begin
                        if (!r_phase) begin
                            n_k = {r_k[6:0], 1'b0};
                            n_state = gfnb_pkg::INV_EXP[r_i] ? S_INV_R1 : S_INV_NXT;
                        end else begin
                            n_k = r_k + 8'd1;
                            n_state = S_INV_NXT;
                        end
                    end
                    default: n_state = S_OUT;
                endcase
            end
            S_INV_ROT: begin
                if (r_cnt == r_k) begin
                    o_cmd.y_sel = gfnb_pkg::Y_P;
                    n_phase = 1'b0;
                    n_mcnt  = '0;
                    n_state = S_MUL;
                end else begin
                    o_cmd.x_sel = gfnb_pkg::X_ROTD;
                    n_cnt = r_cnt + 8'd1;
                end
            end
            S_INV_R1: begin
                o_cmd.x_sel = gfnb_pkg::X_ROTD;
                o_cmd.y_sel = gfnb_pkg::Y_A;
                n_phase = 1'b1;
                n_mcnt  = '0;
                n_state = S_MUL;
            end
            S_INV_NXT: begin
                o_cmd.p_sel = gfnb_pkg::P_X;
                n_cnt = '0;
                if (r_i == 3'd0) begin
                    n_state = S_FIN_ROT;
                end else begin
                    n_i = r_i - 3'd1;
                    n_state = S_INV_ROT;
                end
            end
            S_FIN_ROT: begin
                o_cmd.x_sel = gfnb_pkg::X_ROTD;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (out_xfer) begin
                    if (o_out_last) begin
                        n_widx  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_widx = r_widx + 2'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_idx = r_widx;

    a_no_mul_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_cmd.mul_step)
        else $error("multiplier stepping while a result is offered");
    a_mul_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && r_mcnt == gfnb_pkg::FB_LAST) |=> r_state == S_MUL_END)
        else $error("multiply did not end after 173 steps");
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && o_out_last) |=> (r_state == S_IDLE && r_widx == 2'd0))
        else $error("final result transfer did not return to idle");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_widx != gfnb_pkg::WIDX_NONE))
        else $error("result index out of range");

endmodule

// File: rtl/gf2m_normal_basis_alu_unit.sv
// GF(2^173) optimal normal basis ALU, top level: gfnb_ctrl plus gfnb_dpath.
// Depends on gfnb_pkg, gfnb_in_if, gfnb_out_if.
// Power uses up to 172 multiplies; inverse uses 10 multiplies.
// One operation at a time: input taken only while idle, results one word per cycle while ready.
// Synchronous active-low reset clears the sequencer and zeroes both operand stores.
module gf2m_normal_basis_alu_unit (
    input logic       i_clk,
    input logic       i_rst_n,
    gfnb_in_if.sink   i_in,
    gfnb_out_if.source o_out
);
    gfnb_pkg::t_dp_cmd    dp_cmd;
    gfnb_pkg::t_dp_status dp_status;
    logic [1:0]           out_idx;
    logic                 in_ready;
    logic                 wr_en;

    assign wr_en      = i_in.valid && in_ready && (i_in.word_index != gfnb_pkg::WIDX_NONE);
    assign i_in.ready = in_ready;

    gfnb_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_command    (i_in.command),
        .i_word_index (i_in.word_index),
        .o_in_ready   (in_ready),
        .i_status     (dp_status),
        .o_cmd        (dp_cmd),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_out_idx    (out_idx),
        .o_out_last   (o_out.last)
    );

    gfnb_dpath u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_idx  (i_in.word_index),
        .i_a_word  (i_in.operand_a_word),
        .i_b_word  (i_in.operand_b_word),
        .i_cmd     (dp_cmd),
        .i_out_idx (out_idx),
        .o_status  (dp_status),
        .o_word    (o_out.result_word)
    );

    assign o_out.result_index = out_idx;

endmodule

// File: test/tb.sv
// tb: self-checking testbench for gf2m_normal_basis_alu_unit (GF(2^173) normal basis ALU).
// Uses gfnb_pkg, gfnb_in_if and gfnb_out_if. Checks every result word against a
// behavioral normal basis model kept in this file.
`timescale 1ns / 1ps

module tb;

    localparam int LIMIT = 4_000_000;

    typedef struct packed {
        logic [63:0] word;
        logic [1:0]  index;
        logic        last;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    gfnb_in_if  in_ch ();
    gfnb_out_if out_ch ();

    gf2m_normal_basis_alu_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    gfnb_pkg::t_elem onb_col [gfnb_pkg::FIELD_BITS];
    logic [63:0]     a_words [gfnb_pkg::WORD_COUNT];
    logic [63:0]     b_words [gfnb_pkg::WORD_COUNT];
    t_result         result_q [$];
    int              fails;
    int              cycles;
    int              items_sent;
    int              ops_started;
    int              words_checked;
    bit              idle_en;
    int              hold_left;
    int              stall_left;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Massey-Omura matrix columns: bit (172-i) of column j set when 2^i +- 2^j == +-1 mod p
    task automatic build_matrix();
        int pw [gfnb_pkg::FIELD_BITS];
        int v;
        int s;
        int d;
        v = 1;
        for (int i = 0; i < gfnb_pkg::FIELD_BITS; i++) begin
            pw[i] = v;
            v = (v * 2) % gfnb_pkg::ONB_P;
        end
        for (int j = 0; j < gfnb_pkg::FIELD_BITS; j++) begin
            onb_col[j] = '0;
            for (int i = 0; i < gfnb_pkg::FIELD_BITS; i++) begin
                s = (pw[i] + pw[j]) % gfnb_pkg::ONB_P;
                d = pw[i] - pw[j];
                if (s == 1 || s == gfnb_pkg::ONB_P - 1 || d == 1 || d == -1 ||
                    d == gfnb_pkg::ONB_P - 1 || d == 1 - gfnb_pkg::ONB_P) begin
                    onb_col[j][gfnb_pkg::FIELD_BITS-1-i] = 1'b1;
                end
            end
        end
    endtask

    function automatic gfnb_pkg::t_elem sqr_elem(gfnb_pkg::t_elem a);
        return {a[0], a[gfnb_pkg::FIELD_BITS-1:1]};
    endfunction

    function automatic gfnb_pkg::t_elem mul_elem(gfnb_pkg::t_elem a, gfnb_pkg::t_elem b);
        gfnb_pkg::t_elem r;
        gfnb_pkg::t_elem t;
        r = '0;
        for (int l = 0; l < gfnb_pkg::FIELD_BITS; l++) begin
            for (int j = 0; j < gfnb_pkg::FIELD_BITS; j++) begin
                t[gfnb_pkg::FIELD_BITS-1-j] = ^(onb_col[j] & a);
            end
            r[gfnb_pkg::FIELD_BITS-1-l] = ^(t & b);
            a = {a[gfnb_pkg::FIELD_BITS-2:0], a[gfnb_pkg::FIELD_BITS-1]};
            b = {b[gfnb_pkg::FIELD_BITS-2:0], b[gfnb_pkg::FIELD_BITS-1]};
        end
        return r;
    endfunction

    function automatic gfnb_pkg::t_elem pow_elem(gfnb_pkg::t_elem a, gfnb_pkg::t_elem e);
        gfnb_pkg::t_elem r;
        int              h;
        h = -1;
        for (int i = gfnb_pkg::FIELD_BITS - 1; i >= 0; i--) begin
            if (e[i] && h < 0) h = i;
        end
        if (h < 0) return '1;
        r = a;
        for (int i = h - 1; i >= 0; i--) begin
            r = sqr_elem(r);
            if (e[i]) r = mul_elem(r, a);
        end
        return r;
    endfunction

    // Itoh-Tsujii addition chain for 172
    function automatic gfnb_pkg::t_elem inv_elem(gfnb_pkg::t_elem a);
        gfnb_pkg::t_elem cur;
        gfnb_pkg::t_elem prev;
        int              n;
        int              top;
        int              k;
        cur = a;
        prev = a;
        n = gfnb_pkg::FIELD_BITS - 1;
        top = 0;
        k = 1;
        while ((n >> (top + 1)) != 0) top++;
        for (int i = top - 1; i >= 0; i--) begin
            for (int j = 0; j < k; j++) cur = sqr_elem(cur);
            cur = mul_elem(cur, prev);
            k = k * 2;
            if ((n >> i) & 1) begin
                cur = sqr_elem(cur);
                cur = mul_elem(cur, a);
                k++;
            end
            prev = cur;
        end
        return sqr_elem(cur);
    endfunction

    task automatic queue_result(logic [63:0] w, logic [1:0] idx, logic lst);
        t_result e;
        e.word  = w;
        e.index = idx;
        e.last  = lst;
        result_q.insert(result_q.size(), e);
    endtask

    task automatic predict_transfer(logic [2:0] cmd, logic [1:0] idx,
                                    logic [63:0] aw, logic [63:0] bw);
        gfnb_pkg::t_elem a;
        gfnb_pkg::t_elem b;
        gfnb_pkg::t_elem r;
        if (idx == gfnb_pkg::WIDX_NONE) return;
        a_words[idx] = aw;
        b_words[idx] = bw;
        if (idx != gfnb_pkg::WIDX_START || cmd > gfnb_pkg::OP_TRACE) return;
        ops_started++;
        a = {a_words[2][gfnb_pkg::TOP_BITS-1:0], a_words[1], a_words[0]};
        b = {b_words[2][gfnb_pkg::TOP_BITS-1:0], b_words[1], b_words[0]};
        if (cmd == gfnb_pkg::OP_TRACE) begin
            queue_result({63'd0, ^a}, 2'd0, 1'b1);
            return;
        end
        case (cmd)
            gfnb_pkg::OP_ADD: r = a ^ b;
            gfnb_pkg::OP_MUL: r = mul_elem(a, b);
            gfnb_pkg::OP_SQR: r = sqr_elem(a);
            gfnb_pkg::OP_POW: r = pow_elem(a, b);
            default:          r = inv_elem(a);
        endcase
        queue_result(r[63:0], 2'd0, 1'b0);
        queue_result(r[127:64], 2'd1, 1'b0);
        queue_result({19'd0, r[gfnb_pkg::FIELD_BITS-1:128]}, 2'd2, 1'b1);
    endtask

    task automatic send_item(logic [2:0] cmd, logic [1:0] idx,
                             logic [63:0] aw, logic [63:0] bw);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.command        <= cmd;
        in_ch.word_index     <= idx;
        in_ch.operand_a_word <= aw;
        in_ch.operand_b_word <= bw;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        predict_transfer(cmd, idx, aw, bw);
        items_sent++;
    endtask

    task automatic send_op(logic [2:0] cmd, gfnb_pkg::t_elem a, logic [191:0] b);
        logic [191:0] aw;
        logic [31:0]  junk;
        junk = $urandom;
        aw = {junk[18:0], a};
        if ($urandom_range(0, 1)) aw[191:gfnb_pkg::FIELD_BITS] = '0;
        for (int k = 0; k < gfnb_pkg::WORD_COUNT; k++) begin
            send_item(cmd, 2'(k), aw[64*k +: 64], b[64*k +: 64]);
        end
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (result_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic gfnb_pkg::t_elem rand_elem();
        return gfnb_pkg::t_elem'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    endfunction

    task automatic test_directed();
        gfnb_pkg::t_elem r;
        r = rand_elem();
        send_op(gfnb_pkg::OP_ADD, '1, '1);
        send_op(gfnb_pkg::OP_ADD, '0, {64'hffff_ffff_ffff_ffff, 128'(r)});
        send_op(gfnb_pkg::OP_MUL, '1, 192'(r));
        send_op(gfnb_pkg::OP_MUL, rand_elem(), 192'(rand_elem()));
        send_op(gfnb_pkg::OP_SQR, r, '0);
        send_op(gfnb_pkg::OP_POW, '0, '0);
        send_op(gfnb_pkg::OP_POW, r, {19'h7ffff, 173'd0});
        send_op(gfnb_pkg::OP_POW, r, 192'd1);
        send_op(gfnb_pkg::OP_INV, '0, '0);
        send_op(gfnb_pkg::OP_INV, r, '0);
        send_op(gfnb_pkg::OP_TRACE, '1, '0);
        send_op(gfnb_pkg::OP_TRACE, r, '0);
        send_item(3'd6, gfnb_pkg::WIDX_START, '1, '1);
        send_item(3'd7, gfnb_pkg::WIDX_NONE, 64'h0123_4567_89ab_cdef, '0);
        send_item(gfnb_pkg::OP_ADD, 2'd1, '0, '1);
        wait_drained();
    endtask

    // receiver holds off while the sender keeps offering; block fills and stalls
    task automatic test_backpressure();
        wait_drained();
        hold_left = 500;
        send_op(gfnb_pkg::OP_MUL, rand_elem(), 192'(rand_elem()));
        send_op(gfnb_pkg::OP_ADD, rand_elem(), 192'(rand_elem()));
        send_op(gfnb_pkg::OP_SQR, rand_elem(), '0);
        wait_drained();
    endtask

    task automatic rand_op();
        logic [2:0]   cmd;
        logic [191:0] b;
        cmd = 3'($urandom_range(0, 5));
        b = 192'(rand_elem()) | {$urandom, 160'd0};
        if (cmd == gfnb_pkg::OP_POW && $urandom_range(0, 5) != 0) begin
            b = 192'($urandom_range(0, 4095));
        end
        send_op(cmd, rand_elem(), b);
    endtask

    task automatic test_random(int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 6) != 0) rand_op();
            else send_item(3'($urandom), 2'($urandom), {$urandom, $urandom},
                           {$urandom, $urandom});
        end
    endtask

    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (result_q.size() == 0) begin
                $error("unexpected result transfer word=%h", out_ch.result_word);
                fails++;
            end else begin
                exp_r = result_q.pop_front();
                words_checked++;
                if (out_ch.result_word !== exp_r.word) begin
                    $error("result_word exp %h got %h", exp_r.word, out_ch.result_word);
                    fails++;
                end
                if (out_ch.result_index !== exp_r.index) begin
                    $error("result_index exp %0d got %0d", exp_r.index, out_ch.result_index);
                    fails++;
                end
                if (out_ch.last !== exp_r.last) begin
                    $error("last exp %0d got %0d", exp_r.last, out_ch.last);
                    fails++;
                end
            end
        end
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if (idle_en && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 16);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("gf2m_normal_basis_alu_unit test failed");
            $finish;
        end
    end

    initial begin
        fails = 0;
        cycles = 0;
        items_sent = 0;
        ops_started = 0;
        words_checked = 0;
        hold_left = 0;
        stall_left = 0;
        idle_en = 1'b1;
        for (int k = 0; k < gfnb_pkg::WORD_COUNT; k++) begin
            a_words[k] = '0;
            b_words[k] = '0;
        end
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.command = '0;
        in_ch.word_index = '0;
        in_ch.operand_a_word = '0;
        in_ch.operand_b_word = '0;
        build_matrix();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_random(40);
        idle_en = 1'b0;
        test_random(15);

        wait_drained();
        repeat (50) @(posedge i_clk);
        $display("covered %0d input transfers, %0d operations, %0d result words checked",
                 items_sent, ops_started, words_checked);
        if (fails == 0) begin
            $display("gf2m_normal_basis_alu_unit test passed");
        end else begin
            $display("gf2m_normal_basis_alu_unit test failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/gfnb_pkg.sv
rtl/gfnb_if.sv
rtl/gfnb_dpath.sv
rtl/gfnb_ctrl.sv
rtl/gf2m_normal_basis_alu_unit.sv
test/tb.sv
